### design/efsd_pkg.sv
// ----------------------------------------------------------------------------
// efsd_pkg
// Widths, defaults and controller state codes for the earliest free server
// dispatcher.
// ----------------------------------------------------------------------------
package efsd_pkg;

  localparam int TAG_W = 20;
  localparam int DUR_W = 16;
  localparam int IDX_W = 8;
  localparam int CNT_W = 9;
  localparam int TIME_W = 48;

  localparam int MAX_SERVERS_DEF = 256;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] S_CLEAR = 2'd0;
  localparam logic [ST_W-1:0] S_IDLE = 2'd1;
  localparam logic [ST_W-1:0] S_SCAN = 2'd2;
  localparam logic [ST_W-1:0] S_UPD = 2'd3;

endpackage

### design/earliest_free_server_dispatch.sv
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch
// Sends each job to the active server that becomes free earliest, lowest
// index on a tie, and advances that server's free time by the job duration.
// ----------------------------------------------------------------------------
// Flow: after an accepted start the free-time memory is scanned one word per
// cycle through its single read port over the n active servers, then written
// back once, and the done strobe follows. A new job is taken only once the
// previous one has been written back.
// Reset: a clearing pass zeroes every memory word, busy is high meanwhile.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module earliest_free_server_dispatch
  import efsd_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              server_count_we,
  input  logic [CNT_W-1:0]  server_count,
  input  logic              start,
  output logic              busy,
  input  logic [TAG_W-1:0]  job_tag,
  input  logic [DUR_W-1:0]  duration,
  output logic              done,
  output logic [TAG_W-1:0]  out_tag,
  output logic [IDX_W-1:0]  server_index,
  output logic [TIME_W-1:0] finish_time
);

  localparam int AW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam logic [31:0] MAX_U = 32'(MAX_SERVERS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_SERVERS - 1);

  logic [ST_W-1:0]   state;
  logic [ST_W-1:0]   state_next;
  logic [CNT_W-1:0]  cfg_count;
  logic [AW-1:0]     clr_idx;
  logic [AW-1:0]     issue_idx;
  logic [AW-1:0]     chk_idx;
  logic              chk_last;
  logic [AW-1:0]     last;
  logic [AW-1:0]     last_next;
  logic [AW-1:0]     best_idx;
  logic [TIME_W-1:0] best_time;
  logic [TAG_W-1:0]  tag;
  logic [DUR_W-1:0]  dur;
  logic [31:0]       cnt32;
  logic [31:0]       last32;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] new_time;
  logic [IDX_W+AW-1:0] idx_wide;

  logic              we;
  logic [AW-1:0]     waddr;
  logic [TIME_W-1:0] wdata;
  logic [AW-1:0]     raddr;
  logic [TIME_W-1:0] rdata;

  efsd_ram #(
    .WIDTH(TIME_W),
    .DEPTH(MAX_SERVERS),
    .AW(AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    cnt32 = {{(32-CNT_W){1'b0}}, cfg_count};
    if (cnt32 == 32'd0) begin
      last32 = 32'd0;
    end else if (cnt32 > MAX_U) begin
      last32 = MAX_U - 32'd1;
    end else begin
      last32 = cnt32 - 32'd1;
    end
    last_next = last32[AW-1:0];
  end

  assign sum = {1'b0, best_time} + {{(TIME_W+1-DUR_W){1'b0}}, dur};
  assign new_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign idx_wide = {{IDX_W{1'b0}}, best_idx};

  assign busy = (state != S_IDLE);
  assign we = (state == S_CLEAR) || (state == S_UPD);
  assign waddr = (state == S_CLEAR) ? clr_idx : best_idx;
  assign wdata = (state == S_CLEAR) ? '0 : new_time;
  assign raddr = (state == S_SCAN) ? issue_idx : '0;

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_idx == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_last) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cfg_count <= CNT_W'(1);
      clr_idx <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == S_UPD);
      if (server_count_we) begin
        cfg_count <= server_count;
      end
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          tag <= job_tag;
          dur <= duration;
          last <= last_next;
          issue_idx <= AW'(1);
          chk_idx <= '0;
          chk_last <= (last_next == '0);
        end
      end
      S_SCAN: begin
        if ((chk_idx == '0) || (rdata < best_time)) begin
          best_time <= rdata;
          best_idx <= chk_idx;
        end
        chk_idx <= issue_idx;
        chk_last <= (issue_idx == last);
        issue_idx <= issue_idx + AW'(1);
      end
      S_UPD: begin
        out_tag <= tag;
        server_index <= idx_wide[IDX_W-1:0];
        finish_time <= new_time;
      end
      default: begin
      end
    endcase
  end

  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_UPD))
    else $error("result strobe without a preceding update");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (chk_idx <= last))
    else $error("scan ran past the last active server");

  a_time_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (new_time >= best_time))
    else $error("free time moved backwards");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) || (state == S_SCAN)) |-> !we)
    else $error("memory written outside clear or update");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (best_idx <= last))
    else $error("chosen server outside the active range");

endmodule

### design/efsd_ram.sv
// ----------------------------------------------------------------------------
// efsd_ram
// Generic single-clock RAM with one write port and one read port; the read
// data is registered.
// ----------------------------------------------------------------------------
module efsd_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the earliest free server dispatcher. Jobs are
// sent in random bursts through several server counts, the extremes among
// them. A scoreboard keeps its own copy of every server's free time, works out
// the dispatch for each accepted job and checks each done transfer against it.
// ----------------------------------------------------------------------------
import efsd_pkg::*;

typedef struct packed {
  logic [TAG_W-1:0]  tag;
  logic [IDX_W-1:0]  server;
  logic [TIME_W-1:0] finish;
} dispatch_t;

class dispatch_scoreboard;
  logic [TIME_W-1:0] free_time [MAX_SERVERS_DEF];
  logic [CNT_W-1:0]  count_reg;
  dispatch_t         expected_dispatches[$];
  int                error_count;

  function new();
    foreach (free_time[i]) free_time[i] = '0;
    count_reg = CNT_W'(1);
    error_count = 0;
  endfunction

  function void write_count(logic [CNT_W-1:0] value);
    count_reg = value;
  endfunction

  function int outstanding();
    return expected_dispatches.size();
  endfunction

  // Picks the earliest free active server and advances its free time.
  function void note_job(logic [TAG_W-1:0] tag, logic [DUR_W-1:0] dur);
    int            active;
    int            best;
    logic [TIME_W:0] sum;
    dispatch_t     d;
    active = (count_reg == 0) ? 1 : int'(count_reg);
    if (active > MAX_SERVERS_DEF) active = MAX_SERVERS_DEF;
    best = 0;
    for (int i = 1; i < active; i++) begin
      if (free_time[i] < free_time[best]) best = i;
    end
    sum = {1'b0, free_time[best]} + {{(TIME_W + 1 - DUR_W){1'b0}}, dur};
    free_time[best] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    d.tag = tag;
    d.server = IDX_W'(best);
    d.finish = free_time[best];
    expected_dispatches.push_back(d);
  endfunction

  function void check_result(logic [TAG_W-1:0] tag, logic [IDX_W-1:0] server,
                             logic [TIME_W-1:0] finish);
    dispatch_t d;
    if (expected_dispatches.size() == 0) begin
      $error("unexpected result: out_tag %0h server_index %0d finish_time %0h",
             tag, server, finish);
      error_count++;
      return;
    end
    d = expected_dispatches.pop_front();
    if (tag !== d.tag) begin
      $error("out_tag: expected %0h, actual %0h", d.tag, tag);
      error_count++;
    end
    if (server !== d.server) begin
      $error("server_index: expected %0d, actual %0d", d.server, server);
      error_count++;
    end
    if (finish !== d.finish) begin
      $error("finish_time: expected %0h, actual %0h", d.finish, finish);
      error_count++;
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_JOBS = 600;

  logic              clk;
  logic              rst;
  logic              server_count_we;
  logic [CNT_W-1:0]  server_count;
  logic              start;
  logic              busy;
  logic [TAG_W-1:0]  job_tag;
  logic [DUR_W-1:0]  duration;
  logic              done;
  logic [TAG_W-1:0]  out_tag;
  logic [IDX_W-1:0]  server_index;
  logic [TIME_W-1:0] finish_time;

  dispatch_scoreboard sb = new();
  int cycle_count = 0;

  earliest_free_server_dispatch uut (
    .clk(clk),
    .rst(rst),
    .server_count_we(server_count_we),
    .server_count(server_count),
    .start(start),
    .busy(busy),
    .job_tag(job_tag),
    .duration(duration),
    .done(done),
    .out_tag(out_tag),
    .server_index(server_index),
    .finish_time(finish_time)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (server_count_we) sb.write_count(server_count);
      if (start && !busy) sb.note_job(job_tag, duration);
      if (done) sb.check_result(out_tag, server_index, finish_time);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Holds start high, waiting on the clock until busy is seen low; start is left
  // high so that a following job can go straight on.
  task send_job(logic [TAG_W-1:0] tag, logic [DUR_W-1:0] dur);
    start <= 1'b1;
    job_tag <= tag;
    duration <= dur;
    do @(posedge clk); while (busy);
  endtask

  task pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0 || busy);
  endtask

  task set_count(logic [CNT_W-1:0] value);
    drain();
    server_count_we <= 1'b1;
    server_count <= value;
    @(posedge clk);
    server_count_we <= 1'b0;
  endtask

  function automatic logic [DUR_W-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0, 1: return '0;
      2: return '1;
      3: return DUR_W'($urandom_range(1, 3));
      default: return DUR_W'($urandom());
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CNT_W'(MAX_SERVERS_DEF);
      2: return CNT_W'($urandom_range(MAX_SERVERS_DEF + 1, 511));
      3: return CNT_W'($urandom_range(17, MAX_SERVERS_DEF - 1));
      default: return CNT_W'($urandom_range(1, 16));
    endcase
  endfunction

  task run_jobs(int jobs);
    int left;
    int burst;
    left = jobs;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      repeat (burst) send_job(TAG_W'($urandom()), pick_duration());
      left -= burst;
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
    end
  endtask

  initial begin
    int sent;
    int jobs;
    logic [CNT_W-1:0] cnt;
    rst = 1'b1;
    server_count_we = 1'b0;
    server_count = '0;
    start = 1'b0;
    job_tag = '0;
    duration = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_job('0, '0);
    send_job('1, '1);
    send_job(20'h5A5A5, 16'd1);
    set_count('0);
    send_job(20'h00001, '0);
    send_job(20'h00002, 16'd100);
    set_count(CNT_W'(4));
    send_job(20'h00003, '0);
    send_job(20'h00004, 16'd5);
    send_job(20'h00005, 16'd5);
    send_job(20'h00006, 16'd5);
    send_job(20'h00007, '0);
    set_count('1);
    send_job(20'h00008, 16'd7);
    send_job(20'h00009, '0);
    send_job(20'hAAAAA, 16'hAAAA);
    set_count(CNT_W'(MAX_SERVERS_DEF));
    send_job(20'h55555, 16'h5555);
    send_job(20'h0000A, '1);
    set_count(CNT_W'(2));
    send_job(20'h0000B, 16'd3);
    send_job(20'h0000C, 16'd3);

    sent = 0;
    while (sent < RANDOM_JOBS) begin
      cnt = pick_count();
      set_count(cnt);
      jobs = (cnt > 32) ? 10 : $urandom_range(30, 70);
      run_jobs(jobs);
      sent += jobs;
    end

    drain();
    repeat (MAX_SERVERS_DEF + 8) @(posedge clk);
    if (sb.error_count == 0 && sb.outstanding() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
